@@ hw/rtl/rect_query_result_cache_defines.svh @@
// Assertion macros shared by the rectangle query result cache RTL.
// Included by the top level; no other dependencies.
`ifndef RECT_QUERY_RESULT_CACHE_DEFINES_SVH
`define RECT_QUERY_RESULT_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define RQC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rect_query_result_cache: check failed");
`define RQC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rect_query_result_cache: check failed");
`else
`define RQC_ASSERT_IMPL(label, clk, rst_n, a, b)
`define RQC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ hw/rtl/rqc_pkg.sv @@
// Types, constants and helper functions of the rectangle query result cache.
// No dependencies; used by the top level.
package rqc_pkg;

    localparam int CONTEXTS = 4;
    localparam int ENTRIES  = 8;
    localparam int SLOTS    = CONTEXTS * ENTRIES;
    localparam int CTX_W    = $clog2(CONTEXTS);
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W   = CTX_W + IDX_W;
    localparam int LEN_W    = $clog2(ENTRIES + 2);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 16;
    localparam logic [31:0] BIAS = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_MARGIN = 1'b1;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } corner_t;

    typedef struct packed {
        corner_t     lower_min;
        corner_t     lower_max;
        corner_t     upper_min;
        corner_t     upper_max;
        logic [4:0]  scale;
        logic [15:0] handle;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SHIFT,
        ST_INSERT
    } state_t;

    function automatic logic le_s(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) <= $signed(b);
    endfunction

    // Saturating widening in the biased (order preserving unsigned) domain.
    function automatic logic [31:0] sat_sub(input logic [31:0] v, input logic [15:0] m);
        logic [32:0] d;
        d = {1'b0, v ^ BIAS} - {17'b0, m};
        return (d[32] ? 32'h0 : d[31:0]) ^ BIAS;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [15:0] m);
        logic [32:0] s;
        s = {1'b0, v ^ BIAS} + {17'b0, m};
        return (s[32] ? 32'hFFFF_FFFF : s[31:0]) ^ BIAS;
    endfunction

    function automatic logic entry_match(input entry_t e, input logic [4:0] sc,
                                         input corner_t qmin, input corner_t qmax);
        return (e.scale == sc) &&
               le_s(qmin.x, e.lower_min.x) && le_s(qmin.y, e.lower_min.y) &&
               le_s(e.lower_max.x, qmax.x) && le_s(e.lower_max.y, qmax.y) &&
               le_s(e.upper_min.x, qmin.x) && le_s(e.upper_min.y, qmin.y) &&
               le_s(qmax.x, e.upper_max.x) && le_s(qmax.y, e.upper_max.y);
    endfunction

endpackage

@@ hw/rtl/rqc_req_if.sv @@
// Request channel of the rectangle query result cache.
// Depends on nothing but plain logic types.
interface rqc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  context_id;
    logic [4:0]  scale;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [15:0] fill_handle;

    modport source (output valid, context_id, scale, min_x, min_y, max_x, max_y,
                    fill_handle, input ready);
    modport sink (input valid, context_id, scale, min_x, min_y, max_x, max_y,
                  fill_handle, output ready);
endinterface

@@ hw/rtl/rqc_rsp_if.sv @@
// Response channel of the rectangle query result cache.
// Depends on nothing but plain logic types.
interface rqc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [15:0] result_handle;

    modport source (output valid, hit, result_handle, input ready);
    modport sink (input valid, hit, result_handle, output ready);
endinterface

@@ hw/rtl/rqc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ hw/rtl/rect_query_result_cache.sv @@
// Rectangle query result cache: per-context most-recently-used lists of
// rectangle queries. Uses rqc_pkg, rqc_req_if, rqc_rsp_if and rqc_ram.
//
// Usage: a request transaction on req carries a context, a scale, a query
// rectangle and a handle to install on a miss. Exactly one response
// transaction on rsp follows, carrying the hit flag and the handle of the
// list's front entry after the update.
// The lists live in one RAM with registered read data. The context's list
// is scanned from the front, one entry per cycle. A hit at the front answers
// right away; a hit further down is first swapped with the front entry in
// ST_SWAP_A and ST_SWAP_B. A miss moves each kept entry down by one, one
// entry per cycle, then writes the new entry at the front in ST_INSERT. The
// next request is taken only once the response has left its register.
// Reset empties every list and restores max_entries to 8 and inflate_margin
// to 16; no clearing pass is needed. While the receiver stalls, the response
// holds in its register and req stays not ready.
// Configuration writes on cfg_we/cfg_index/cfg_data are meant for idle time.
`include "rect_query_result_cache_defines.svh"
module rect_query_result_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    rqc_req_if.sink                       req,
    rqc_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [rqc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rqc_pkg::CFG_W-1:0]     cfg_data
);
    import rqc_pkg::*;

    state_t               state_reg, state_next;
    logic [3:0]           max_entries_reg;
    logic [15:0]          margin_reg;
    logic [LEN_W-1:0]     list_length_reg [CONTEXTS];

    logic [CTX_W-1:0]     ctx_reg, ctx_next;
    logic [4:0]           scale_reg, scale_next;
    corner_t              qmin_reg, qmin_next;
    corner_t              qmax_reg, qmax_next;
    logic [15:0]          fill_reg, fill_next;
    logic [LEN_W-1:0]     len_reg, len_next;

    logic [LEN_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    entry_t               front_reg, front_next;
    entry_t               match_reg, match_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;

    logic [IDX_W-1:0]     sh_idx_reg, sh_idx_next;
    logic                 sh_left_reg, sh_left_next;
    logic                 sh_wr_reg, sh_wr_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [15:0]          out_handle_reg, out_handle_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_wr_addr;
    entry_t               ram_wr_data;
    logic [SLOT_W-1:0]    ram_rd_addr;
    entry_t               rd_entry;

    logic                 len_we;
    logic [LEN_W-1:0]     cap;
    logic [LEN_W-1:0]     nlen;
    logic [LEN_W-1:0]     req_len;
    entry_t               new_entry;

    rqc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_entry)
    );

    // Register value 0 behaves as 1, values above the list size as the list size.
    always_comb
    begin
        if (max_entries_reg == 4'd0)
        begin
            cap = LEN_W'(1);
        end
        else if (LEN_W'(max_entries_reg) > LEN_W'(ENTRIES) || max_entries_reg > 4'(ENTRIES))
        begin
            cap = LEN_W'(ENTRIES);
        end
        else
        begin
            cap = LEN_W'(max_entries_reg);
        end
        nlen = ((len_reg + LEN_W'(1)) > cap) ? cap : (len_reg + LEN_W'(1));
        req_len = (list_length_reg[req.context_id] > LEN_W'(ENTRIES)) ?
                  LEN_W'(ENTRIES) : list_length_reg[req.context_id];
    end

    always_comb
    begin
        new_entry.lower_min   = qmin_reg;
        new_entry.lower_max   = qmax_reg;
        new_entry.upper_min.x = sat_sub(qmin_reg.x, margin_reg);
        new_entry.upper_min.y = sat_sub(qmin_reg.y, margin_reg);
        new_entry.upper_max.x = sat_add(qmax_reg.x, margin_reg);
        new_entry.upper_max.y = sat_add(qmax_reg.y, margin_reg);
        new_entry.scale       = scale_reg;
        new_entry.handle      = fill_reg;
    end

    assign req.ready         = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.result_handle = out_handle_reg;

    always_comb
    begin
        state_next      = state_reg;
        ctx_next        = ctx_reg;
        scale_next      = scale_reg;
        qmin_next       = qmin_reg;
        qmax_next       = qmax_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        front_next      = front_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        sh_idx_next     = sh_idx_reg;
        sh_left_next    = sh_left_reg;
        sh_wr_next      = 1'b0;
        wr_idx_next     = wr_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_handle_next = out_handle_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = {ctx_reg, IDX_W'(0)};
        ram_wr_data     = rd_entry;
        ram_rd_addr     = {ctx_reg, rd_idx_reg[IDX_W-1:0]};
        len_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    ctx_next    = req.context_id;
                    scale_next  = req.scale;
                    qmin_next   = '{x: req.min_x, y: req.min_y};
                    qmax_next   = '{x: req.max_x, y: req.max_y};
                    fill_next   = req.fill_handle;
                    len_next    = req_len;
                    rd_idx_next = '0;
                    state_next  = (req_len == '0) ? ST_INSERT : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (chk_vld_reg && entry_match(rd_entry, scale_reg, qmin_reg, qmax_reg))
                begin
                    if (chk_idx_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_hit_next    = 1'b1;
                        out_handle_next = rd_entry.handle;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        match_next     = rd_entry;
                        match_idx_next = chk_idx_reg;
                        state_next     = ST_SWAP_A;
                    end
                end
                else if (chk_vld_reg && LEN_W'(chk_idx_reg) == len_reg - LEN_W'(1))
                begin
                    // Whole list checked without a match.
                    if (nlen > LEN_W'(1))
                    begin
                        sh_idx_next  = IDX_W'(nlen - LEN_W'(2));
                        sh_left_next = 1'b1;
                        state_next   = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
                else
                begin
                    if (chk_vld_reg && chk_idx_reg == '0)
                    begin
                        front_next = rd_entry;
                    end
                    if (rd_idx_reg < len_reg)
                    begin
                        chk_vld_next = 1'b1;
                        chk_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next  = rd_idx_reg + LEN_W'(1);
                    end
                end
            end

            ST_SWAP_A:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = {ctx_reg, match_idx_reg};
                ram_wr_data = front_reg;
                state_next  = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                ram_we          = 1'b1;
                ram_wr_addr     = {ctx_reg, IDX_W'(0)};
                ram_wr_data     = match_reg;
                out_valid_next  = 1'b1;
                out_hit_next    = 1'b1;
                out_handle_next = match_reg.handle;
                state_next      = ST_IDLE;
            end

            ST_SHIFT:
            begin
                // Read entry j while entry j+1, read the cycle before, lands one slot down.
                if (sh_wr_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = {ctx_reg, wr_idx_reg + IDX_W'(1)};
                    ram_wr_data = rd_entry;
                end
                if (sh_left_reg)
                begin
                    ram_rd_addr = {ctx_reg, sh_idx_reg};
                    wr_idx_next = sh_idx_reg;
                    sh_wr_next  = 1'b1;
                    if (sh_idx_reg == '0)
                    begin
                        sh_left_next = 1'b0;
                    end
                    else
                    begin
                        sh_idx_next = sh_idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                ram_we          = 1'b1;
                ram_wr_addr     = {ctx_reg, IDX_W'(0)};
                ram_wr_data     = new_entry;
                len_we          = 1'b1;
                out_valid_next  = 1'b1;
                out_hit_next    = 1'b0;
                out_handle_next = fill_reg;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_entries_reg <= 4'd8;
            margin_reg      <= 16'd16;
            out_valid_reg   <= 1'b0;
            chk_vld_reg     <= 1'b0;
            sh_left_reg     <= 1'b0;
            sh_wr_reg       <= 1'b0;
            rd_idx_reg      <= '0;
            sh_idx_reg      <= '0;
            len_reg         <= '0;
            ctx_reg         <= '0;
            for (int c = 0; c < CONTEXTS; c++)
            begin
                list_length_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= chk_vld_next;
            sh_left_reg   <= sh_left_next;
            sh_wr_reg     <= sh_wr_next;
            rd_idx_reg    <= rd_idx_next;
            sh_idx_reg    <= sh_idx_next;
            len_reg       <= len_next;
            ctx_reg       <= ctx_next;
            if (len_we)
            begin
                list_length_reg[ctx_reg] <= nlen;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_ENTRIES:    max_entries_reg <= cfg_data[3:0];
                    CFG_INFLATE_MARGIN: margin_reg      <= cfg_data[15:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg      <= scale_next;
        qmin_reg       <= qmin_next;
        qmax_reg       <= qmax_next;
        fill_reg       <= fill_next;
        chk_idx_reg    <= chk_idx_next;
        front_reg      <= front_next;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        wr_idx_reg     <= wr_idx_next;
        out_hit_reg    <= out_hit_next;
        out_handle_reg <= out_handle_next;
    end

    `RQC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `RQC_ASSERT_IMPL(a_swap_not_front, clk, rst_n, state_reg == ST_SWAP_A, match_idx_reg != '0)
    `RQC_ASSERT_IMPL(a_len_bounded, clk, rst_n, len_we, nlen <= LEN_W'(ENTRIES) && nlen != '0)
    `RQC_ASSERT_IMPL(a_shift_in_list, clk, rst_n, state_reg == ST_SHIFT && sh_left_reg,
                     LEN_W'(sh_idx_reg) < len_reg)
endmodule
